// ----- design/nct_pkg.sv -----
// Package for the nested colour tint stack: defaults, action and status codes,
// and the tag match bundle. No dependencies.
`default_nettype none
package nct_pkg;
  localparam int TableEntriesDef = 16;
  localparam int NestDepthDef    = 64;
  localparam int MaxIdxW         = 6;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [2:0] ACT_SET   = 3'd0;
  localparam logic [2:0] ACT_CLEAR = 3'd1;
  localparam logic [2:0] ACT_ENTER = 3'd2;
  localparam logic [2:0] ACT_LEAVE = 3'd3;
  localparam logic [2:0] ACT_COLOR = 3'd4;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_FULL = 2'd1;
  localparam logic [1:0] STS_OVF  = 2'd2;
  localparam logic [1:0] STS_UNF  = 2'd3;

  typedef struct packed {
    logic               hnd_hit;
    logic [MaxIdxW-1:0] hnd_idx;
    logic               free_hit;
    logic [MaxIdxW-1:0] free_idx;
    logic               node_hit;
    logic [MaxIdxW-1:0] node_idx;
  } tag_match_t;
endpackage
`default_nettype wire

// ----- design/nct_in_if.sv -----
// Input channel interface: valid/ready plus the item fields.
// Depends on nothing.
`default_nettype none
interface nct_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] handle;
  logic [31:0] node;
  logic [31:0] color;
  modport source(output valid, action, handle, node, color, input ready);
  modport sink(input valid, action, handle, node, color, output ready);
endinterface
`default_nettype wire

// ----- design/nct_out_if.sv -----
// Result channel interface: valid/ready plus the result fields.
// Depends on nothing.
`default_nettype none
interface nct_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] color_out;
  logic [1:0]  status;
  modport source(output valid, color_out, status, input ready);
  modport sink(input valid, color_out, status, output ready);
endinterface
`default_nettype wire

// ----- design/nct_lane.sv -----
// One 8-bit colour channel: product of two channels divided by 255, floored.
// Depends on nothing.
`default_nettype none
module nct_lane (
  input  wire logic [7:0] x,
  input  wire logic [7:0] y,
  output logic      [7:0] q
);
  logic [15:0] prod;
  logic [16:0] sum;

  // For products up to 255*255 this add-and-shift equals floor(p / 255).
  assign prod = x * y;
  assign sum  = {1'b0, prod} + 17'd1 + {9'd0, prod[15:8]};
  assign q    = sum[15:8];
endmodule
`default_nettype wire

// ----- design/nct_tag_match.sv -----
// Tag table comparators, one per entry, merged into first-hit indexes.
// Depends on nct_pkg.
`default_nettype none
module nct_tag_match
  import nct_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input  wire logic [31:0] handles [TABLE_ENTRIES],
  input  wire logic [31:0] nodes   [TABLE_ENTRIES],
  input  wire logic [31:0] key_handle,
  input  wire logic [31:0] key_node,
  output tag_match_t       match
);
  // Walking downward lets the lowest matching entry win.
  always_comb begin
    match = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (handles[i] == key_handle) begin
        match.hnd_hit = 1'b1;
        match.hnd_idx = MaxIdxW'(i);
      end
      if (handles[i] == 32'd0) begin
        match.free_hit = 1'b1;
        match.free_idx = MaxIdxW'(i);
      end
      if (key_node != 32'd0 && nodes[i] == key_node) begin
        match.node_hit = 1'b1;
        match.node_idx = MaxIdxW'(i);
      end
    end
  end
endmodule
`default_nettype wire

// ----- design/nested_colour_tint_stack.sv -----
// Top level of the nested colour tint stack: sequencer, tag table, nesting
// stack memory and four channel lanes. Depends on nct_pkg, nct_in_if,
// nct_out_if, nct_lane and nct_tag_match.
//
//  channel | direction | payload                        | handshake
//  in_bus  | in        | action, handle, node, color    | valid/ready
//  out_bus | out       | color_out, status              | valid/ready
//  cfg     | in        | cfg_wr_data (global tint)      | cfg_wr_en
//
// From accept to result register: a set, clear, untagged enter, overflow,
// underflow or unused code goes from S_EXEC to S_DONE; a tagged enter or a
// colour under an all-ones tint passes S_MUL1, a leave S_POP, and any other
// colour S_MUL1 and S_MUL2 (two passes through the lanes), as the lanes are
// shared and the stack read is registered. Words are accepted only in S_IDLE;
// a stalled result holds the sequencer until the output register is free.
// Reset empties the table and the nesting levels; the stack itself is not cleared.
`default_nettype none
module nested_colour_tint_stack
  import nct_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int NEST_DEPTH    = NestDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  nct_in_if.sink           in_bus,
  nct_out_if.source        out_bus,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int AW = $clog2(NEST_DEPTH);
  localparam int LW = $clog2(NEST_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_MUL1 = 6'b000100,
    S_MUL2 = 6'b001000,
    S_POP  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  act_r;
  logic [31:0] hnd_r, node_r, col_r;
  logic [31:0] gtint_r, cur_r;
  logic [LW-1:0] level_r, tinted_r;
  logic [31:0] handles_r [TABLE_ENTRIES];
  logic [31:0] nodes_r   [TABLE_ENTRIES];
  logic [31:0] tints_r   [TABLE_ENTRIES];
  logic [32:0] stack_mem [NEST_DEPTH];
  logic [32:0] stk_rd_r;
  logic [31:0] mul_r, res_col_r;
  logic [1:0]  res_sts_r;
  logic        out_valid_r;
  logic [31:0] out_col_r;
  logic [1:0]  out_sts_r;

  tag_match_t  match;
  logic [31:0] mul_x, mul_y, mul_q, col_tint;
  logic        in_fire, out_load, full, empty, stk_we;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] level_dec;
  logic [IW-1:0] hnd_i, free_i, node_i;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);
  assign out_bus.valid     = out_valid_r;
  assign out_bus.color_out = out_col_r;
  assign out_bus.status    = out_sts_r;

  assign full      = (level_r == LW'(NEST_DEPTH));
  assign empty     = (level_r == '0);
  assign level_dec = level_r - LW'(1);
  assign rd_addr   = level_dec[AW-1:0];
  assign hnd_i     = match.hnd_idx[IW-1:0];
  assign free_i    = match.free_idx[IW-1:0];
  assign node_i    = match.node_idx[IW-1:0];
  assign stk_we    = (state_r == S_EXEC) && (act_r == ACT_ENTER) && !full;
  assign col_tint  = (tinted_r != '0) ? mul_r : gtint_r;

  nct_tag_match #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_match (
    .handles    (handles_r),
    .nodes      (nodes_r),
    .key_handle (hnd_r),
    .key_node   (node_r),
    .match      (match)
  );

  for (genvar g = 0; g < 4; g++) begin : g_lane
    nct_lane u_lane (
      .x (mul_x[8*g +: 8]),
      .y (mul_y[8*g +: 8]),
      .q (mul_q[8*g +: 8])
    );
  end

  // Operand selection for the shared channel lanes.
  always_comb begin
    mul_x = col_r;
    mul_y = col_tint;
    if (state_r == S_EXEC) begin
      if (act_r == ACT_ENTER) begin
        mul_x = cur_r;
        mul_y = tints_r[node_i];
      end else begin
        mul_x = gtint_r;
        mul_y = cur_r;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_EXEC;
      S_EXEC: begin
        if (act_r == ACT_COLOR) begin
          state_nxt = S_MUL1;
        end else if (act_r == ACT_ENTER && !full && match.node_hit) begin
          state_nxt = S_MUL1;
        end else if (act_r == ACT_LEAVE && !empty) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL1: begin
        if (act_r == ACT_COLOR && col_tint != ALL_ONES) state_nxt = S_MUL2;
        else state_nxt = S_DONE;
      end
      S_MUL2: state_nxt = S_DONE;
      S_POP:  state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Nesting stack: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[level_r[AW-1:0]] <= {match.node_hit, cur_r};
    end
    stk_rd_r <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_q;
    if (in_fire) begin
      act_r  <= in_bus.action;
      hnd_r  <= in_bus.handle;
      node_r <= in_bus.node;
      col_r  <= in_bus.color;
    end
    if (out_load) begin
      out_col_r <= res_col_r;
      out_sts_r <= res_sts_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gtint_r     <= ALL_ONES;
      cur_r       <= ALL_ONES;
      level_r     <= '0;
      tinted_r    <= '0;
      out_valid_r <= 1'b0;
      res_col_r   <= '0;
      res_sts_r   <= STS_OK;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        handles_r[i] <= '0;
        nodes_r[i]   <= '0;
        tints_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) gtint_r <= cfg_wr_data;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_bus.ready) out_valid_r <= 1'b0;

      case (state_r)
        S_EXEC: begin
          res_col_r <= '0;
          res_sts_r <= STS_OK;
          case (act_r)
            ACT_SET: begin
              if (hnd_r != 32'd0 && node_r != 32'd0) begin
                if (match.hnd_hit) begin
                  nodes_r[hnd_i] <= node_r;
                  tints_r[hnd_i] <= col_r;
                end else if (match.free_hit) begin
                  handles_r[free_i] <= hnd_r;
                  nodes_r[free_i]   <= node_r;
                  tints_r[free_i]   <= col_r;
                end else begin
                  res_sts_r <= STS_FULL;
                end
              end
            end
            ACT_CLEAR: begin
              if (hnd_r != 32'd0 && match.hnd_hit) begin
                handles_r[hnd_i] <= '0;
                nodes_r[hnd_i]   <= '0;
                tints_r[hnd_i]   <= '0;
              end
            end
            ACT_ENTER: begin
              if (full) begin
                res_sts_r <= STS_OVF;
              end else begin
                level_r <= level_r + LW'(1);
                if (match.node_hit) tinted_r <= tinted_r + LW'(1);
              end
            end
            ACT_LEAVE: begin
              if (empty) res_sts_r <= STS_UNF;
              else level_r <= level_dec;
            end
            default: ;
          endcase
        end
        S_MUL1: begin
          if (act_r == ACT_ENTER) cur_r <= mul_r;
          else if (col_tint == ALL_ONES) res_col_r <= col_r;
        end
        S_MUL2: res_col_r <= mul_r;
        S_POP: begin
          if (stk_rd_r[32]) begin
            cur_r <= stk_rd_r[31:0];
            if (tinted_r != '0) tinted_r <= tinted_r - LW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(NEST_DEPTH))
    else $error("nesting level beyond stack depth");

  // On a leave the tinted count drops in S_POP, in the cycle after the level.
  a_tinted_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_POP |-> tinted_r <= level_r)
    else $error("more tinted levels than open levels");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_EXEC)
    else $error("accepted word did not start execution");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == S_IDLE)
    else $error("finished word not presented");
endmodule
`default_nettype wire

// ----- bench/tb_nested_colour_tint_stack.sv -----
// Self-checking testbench for the nested colour tint stack: drives tag, nesting
// and colour words, predicts every result and compares them in order.
// Depends on nct_pkg, nct_in_if, nct_out_if and nested_colour_tint_stack.
`default_nettype none
module tb_nested_colour_tint_stack
  import nct_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Entries = 16;
  localparam int Depth   = 64;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] handle;
    logic [31:0] node;
    logic [31:0] color;
  } tint_word_t;

  typedef struct packed {
    logic [31:0] color_out;
    logic [1:0]  status;
  } tint_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  nct_in_if  in_bus();
  nct_out_if out_bus();

  nested_colour_tint_stack DUT (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Predictor state.
  logic [31:0] wash;
  logic [31:0] tag_hnd [Entries];
  logic [31:0] tag_nd [Entries];
  logic [31:0] tag_tint [Entries];
  logic [32:0] saved [Depth];
  int level;
  int tinted;
  logic [31:0] cur_tint;

  tint_word_t   pending_words[$];
  tint_result_t expected_results[$];
  int mismatches = 0;
  logic hold_sender = 1'b0;

  function automatic logic [31:0] tint_mul(logic [31:0] x, logic [31:0] y);
    logic [31:0] r;
    logic [15:0] p;
    r = '0;
    for (int s = 0; s < 32; s += 8) begin
      p = x[s +: 8] * y[s +: 8];
      r[s +: 8] = 8'(p / 16'd255);
    end
    return r;
  endfunction

  function automatic tint_result_t predict_tint(tint_word_t w);
    tint_result_t r;
    logic [31:0] t;
    int slot;
    bit done;
    r.color_out = '0;
    r.status = STS_OK;
    case (w.action)
      ACT_SET: begin
        if (w.handle != 0 && w.node != 0) begin
          slot = -1;
          done = 1'b0;
          for (int i = 0; i < Entries; i++) begin
            if (!done && tag_hnd[i] == w.handle) begin
              tag_nd[i] = w.node;
              tag_tint[i] = w.color;
              done = 1'b1;
            end
            if (!done && slot < 0 && tag_hnd[i] == 0) slot = i;
          end
          if (!done) begin
            if (slot >= 0) begin
              tag_hnd[slot] = w.handle;
              tag_nd[slot] = w.node;
              tag_tint[slot] = w.color;
            end else begin
              r.status = STS_FULL;
            end
          end
        end
      end
      ACT_CLEAR: begin
        done = 1'b0;
        if (w.handle != 0) begin
          for (int i = 0; i < Entries; i++) begin
            if (!done && tag_hnd[i] == w.handle) begin
              tag_hnd[i] = '0;
              tag_nd[i] = '0;
              tag_tint[i] = '0;
              done = 1'b1;
            end
          end
        end
      end
      ACT_ENTER: begin
        if (level >= Depth) begin
          r.status = STS_OVF;
        end else begin
          saved[level] = {1'b0, cur_tint};
          done = 1'b0;
          if (w.node != 0) begin
            for (int i = 0; i < Entries; i++) begin
              if (!done && tag_nd[i] == w.node) begin
                saved[level][32] = 1'b1;
                cur_tint = tint_mul(cur_tint, tag_tint[i]);
                tinted++;
                done = 1'b1;
              end
            end
          end
          level++;
        end
      end
      ACT_LEAVE: begin
        if (level == 0) begin
          r.status = STS_UNF;
        end else begin
          level--;
          if (saved[level][32]) begin
            cur_tint = saved[level][31:0];
            if (tinted > 0) tinted--;
          end
        end
      end
      ACT_COLOR: begin
        t = wash;
        if (tinted > 0) t = tint_mul(t, cur_tint);
        r.color_out = (t != ALL_ONES) ? tint_mul(w.color, t) : w.color;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: waits a random gap before each word.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.action <= '0;
      in_bus.handle <= '0;
      in_bus.node <= '0;
      in_bus.color <= '0;
    end else if (in_bus.valid && !in_bus.ready) begin
      // hold the word
    end else begin
      if (in_bus.valid) begin
        expected_results.push_back(predict_tint(
          {in_bus.action, in_bus.handle, in_bus.node, in_bus.color}));
        send_gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_bus.valid <= 1'b0;
      end else if (pending_words.size() > 0 && !hold_sender) begin
        tint_word_t w;
        w = pending_words.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.action <= w.action;
        in_bus.handle <= w.handle;
        in_bus.node <= w.node;
        in_bus.color <= w.color;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Monitor: random stalls on the result side, in-order compare.
  int sink_wait = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word color_out=%h status=%0d",
                     out_bus.color_out, out_bus.status);
        end else begin
          tint_result_t e;
          e = expected_results.pop_front();
          if (e.color_out !== out_bus.color_out || e.status !== out_bus.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected color_out=%h status=%0d, got %h %0d",
                       e.color_out, e.status, out_bus.color_out, out_bus.status);
          end
        end
        sink_wait = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) sink_wait = 0;
      end
      if (sink_wait > 0) begin
        sink_wait--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic queue_word(logic [2:0] a, logic [31:0] h, logic [31:0] n,
                            logic [31:0] c);
    tint_word_t w;
    w.action = a;
    w.handle = h;
    w.node = n;
    w.color = c;
    pending_words.push_back(w);
  endtask

  // Handles and nodes come from a small pool so tags hit often.
  function automatic logic [31:0] pool_id();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return $urandom_range(0, 20);
  endfunction

  // Sampled on the falling edge so the driver's updates have settled.
  task automatic drain();
    while (pending_words.size() > 0 || in_bus.valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_wash(logic [31:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    wash = v;
  endtask

  task automatic queue_random(int count);
    int a;
    for (int i = 0; i < count; i++) begin
      a = $urandom_range(0, 99);
      if (a < 15)
        queue_word(ACT_SET, pool_id(), pool_id(), $urandom());
      else if (a < 22)
        queue_word(ACT_CLEAR, pool_id(), 32'd0, $urandom());
      else if (a < 45)
        queue_word(ACT_ENTER, $urandom(), pool_id(), $urandom());
      else if (a < 65)
        queue_word(ACT_LEAVE, $urandom(), $urandom(), $urandom());
      else if (a < 97)
        queue_word(ACT_COLOR, $urandom(), $urandom(), $urandom());
      else
        queue_word(3'($urandom_range(5, 7)), $urandom(), $urandom(), $urandom());
    end
  endtask

  logic [31:0] washes [5] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h80FF_40C0,
                              32'hFFFF_FFFE, 32'h0000_0000};

  initial begin
    wash = ALL_ONES;
    for (int i = 0; i < Entries; i++) begin
      tag_hnd[i] = '0;
      tag_nd[i] = '0;
      tag_tint[i] = '0;
    end
    level = 0;
    tinted = 0;
    cur_tint = ALL_ONES;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ignored sets, tinting, nesting, clears, underflow, unused codes.
    queue_word(ACT_LEAVE, '0, '0, '0);
    queue_word(ACT_SET, 32'd0, 32'd5, 32'h1234_5678);
    queue_word(ACT_SET, 32'd7, 32'd0, 32'h1234_5678);
    queue_word(ACT_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h80FF_00FF);
    queue_word(ACT_SET, 32'd1, 32'd9, 32'hFFFF_FFFF);
    queue_word(ACT_SET, 32'd1, 32'd9, 32'h7F3F_C000);
    queue_word(ACT_COLOR, '0, '0, 32'hFFFF_FFFF);
    queue_word(ACT_ENTER, '0, 32'd0, '0);
    queue_word(ACT_ENTER, '0, 32'd9, '0);
    queue_word(ACT_ENTER, '0, 32'hFFFF_FFFF, '0);
    queue_word(ACT_COLOR, '0, '0, 32'hFFFF_FFFF);
    queue_word(ACT_COLOR, '0, '0, 32'h0000_0000);
    queue_word(ACT_LEAVE, '0, '0, '0);
    queue_word(ACT_COLOR, '0, '0, 32'hA5A5_5A5A);
    queue_word(ACT_CLEAR, 32'd0, '0, '0);
    queue_word(ACT_CLEAR, 32'd99, '0, '0);
    queue_word(ACT_CLEAR, 32'd1, '0, '0);
    queue_word(ACT_LEAVE, '0, '0, '0);
    queue_word(ACT_LEAVE, '0, '0, '0);
    queue_word(ACT_LEAVE, '0, '0, '0);
    queue_word(3'd5, '1, '1, '1);
    queue_word(3'd7, '1, '1, '1);
    drain();

    // Fill the table past full, nest past full depth, unwind past empty, clear.
    for (int i = 0; i < 18; i++) queue_word(ACT_SET, 32'(100 + i), 32'(200 + i), $urandom());
    for (int i = 0; i < Depth + 2; i++) queue_word(ACT_ENTER, '0, 32'(200 + i % 20), '0);
    queue_word(ACT_COLOR, '0, '0, $urandom());
    for (int i = 0; i < Depth + 1; i++) queue_word(ACT_LEAVE, '0, '0, '0);
    for (int i = 0; i < 16; i++) queue_word(ACT_CLEAR, 32'(100 + i), '0, '0);
    drain();

    // Random phases under several washes, with one full-drain pause mid-phase.
    for (int ph = 0; ph < 5; ph++) begin
      write_wash(ph == 4 ? $urandom() : washes[ph]);
      queue_random(87);
      while (pending_words.size() > 0) @(negedge clk);
      hold_sender <= 1'b1;
      @(negedge clk);
      while (in_bus.valid || expected_results.size() > 0) @(negedge clk);
      hold_sender <= 1'b0;
      queue_random(87);
      drain();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS nested_colour_tint_stack");
    end else begin
      $display("FAIL nested_colour_tint_stack");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL nested_colour_tint_stack");
    $finish;
  end
endmodule
`default_nettype wire
